FILE: design/cddn_pkg.sv
// Package for the civil date / day number converter: request/result types, constants, tables.
`default_nettype none
package cddn_pkg;

  // Last year that converts as valid
  localparam logic [15:0] MAX_YEAR = 16'd9999;

  // Operation codes carried in the action field
  localparam logic ACT_TO_COUNT = 1'b0;
  localparam logic ACT_TO_DATE  = 1'b1;

  // Day counts of the Gregorian cycles
  localparam logic [17:0] DAYS_400 = 18'd146097;
  localparam logic [15:0] DAYS_100 = 16'd36524;
  localparam logic [10:0] DAYS_4   = 11'd1461;
  localparam logic [8:0]  DAYS_1   = 9'd365;

  // Reciprocals for division by a constant: q = (x * RECIP) >> SHIFT
  localparam logic [13:0] Y100_RECIP = 14'd10486;
  localparam int          Y100_SHIFT = 20;
  localparam logic [22:0] D400_RECIP = 23'd7525902;
  localparam int          D400_SHIFT = 40;
  localparam logic [15:0] D4_RECIP   = 16'd45934;
  localparam int          D4_SHIFT   = 26;

  typedef struct packed {
    logic        action;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [21:0] count_in;
  } req_t;

  typedef struct packed {
    logic [21:0] count_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic        valid_res;
  } res_t;

  // Day of year on which a month starts, counted from 0
  function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
    logic [8:0] base;
    case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (month > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: design/civil_date_day_number_convert_top.sv
// Top level of the civil date / day number converter, a six-stage pipeline.
`default_nettype none
// Converts between a proleptic Gregorian date and a day number, day 0 being
// January 1 of year 1.
// Request channel: drive req and raise start; the request is taken at every
// rising edge where start is high and busy is low. busy stays low, so a new
// request may enter on every cycle.
//   req.action = ACT_TO_COUNT: year/month/day in, count_out back.
//   req.action = ACT_TO_DATE : count_in in, year/month/day back.
// Result channel: done is high for exactly one cycle with res; the receiver
// must take it then, it cannot hold results off. Results leave in request order.
//
// Throughput: one request per cycle. The depth is set by the reverse path:
// divide by the 400-year cycle (reciprocal multiply), peel the 100-year part,
// divide by the 4-year cycle (second multiply), peel the single years, then
// rebuild the year and search the month table.
// Reset (rst, synchronous) clears the stage valid bits; requests in flight
// are dropped and no done pulse follows for them.
// Fields not used by an action, and every field of an out-of-range request
// except valid_res, return as zero.
module civil_date_day_number_convert_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cddn_pkg::req_t req,
  output logic               done,
  output cddn_pkg::res_t     res
);

  // Stage 1: register the request, start both divisions
  logic        s1_v;
  logic        s1_action;
  logic [13:0] s1_year;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [21:0] s1_count;
  logic [7:0]  s1_qy;
  logic [4:0]  s1_q400;

  logic [27:0] qy_prod;
  logic [44:0] q400_prod;

  // Stage 2
  logic        s2_v;
  logic        s2_action;
  logic        s2_valid0;
  logic [13:0] s2_p;
  logic [7:0]  s2_p100;
  logic [8:0]  s2_doy;
  logic [4:0]  s2_q400;
  logic [17:0] s2_r;

  // Stage 3
  logic        s3_v;
  logic        s3_action;
  logic        s3_valid0;
  logic [22:0] s3_a;
  logic [12:0] s3_corr;
  logic [4:0]  s3_q400;
  logic [1:0]  s3_q100;
  logic [15:0] s3_r2;

  // Stage 4
  logic        s4_v;
  logic        s4_action;
  logic        s4_valid0;
  logic [21:0] s4_count;
  logic [4:0]  s4_q400;
  logic [1:0]  s4_q100;
  logic [4:0]  s4_q4;
  logic [15:0] s4_r2;

  // Stage 5
  logic        s5_v;
  logic        s5_action;
  logic        s5_valid0;
  logic [21:0] s5_count;
  logic [4:0]  s5_q400;
  logic [1:0]  s5_q100;
  logic [4:0]  s5_q4;
  logic [1:0]  s5_q1;
  logic [8:0]  s5_r4;

  cddn_pkg::res_t res_next;

  // The pipeline never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Valid chain: advance one stage per cycle, clear on reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v <= start & ~busy;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      done <= s5_v;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: year / 100 for the leap rule, count / 146097 for the 400-year cycle
  // ---------------------------------------------------------------------------
  assign qy_prod   = 28'(req.year_in) * 28'(cddn_pkg::Y100_RECIP);
  assign q400_prod = 45'(req.count_in) * 45'(cddn_pkg::D400_RECIP);

  always_ff @(posedge clk) begin
    s1_action <= req.action;
    s1_year   <= req.year_in;
    s1_month  <= req.month_in;
    s1_day    <= req.day_in;
    s1_count  <= req.count_in;
    s1_qy     <= qy_prod[cddn_pkg::Y100_SHIFT +: 8];
    s1_q400   <= q400_prod[cddn_pkg::D400_SHIFT +: 5];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: leap year, range check, day of year (date side);
  //          remainder within the 400-year cycle (count side)
  // ---------------------------------------------------------------------------
  logic [6:0]  s2_ry;
  logic [13:0] s2_ry_full;
  logic        s2_leap;
  logic [21:0] s2_r_full;

  always_comb begin
    s2_ry_full = s1_year - (14'(s1_qy) * 14'd100);
    s2_ry      = s2_ry_full[6:0];
    // Leap: divisible by 4, and not a century unless divisible by 400
    s2_leap    = (s1_year[1:0] == 2'b00) && ((s2_ry != 7'd0) || (s1_qy[1:0] == 2'b00));
    s2_r_full  = s1_count - (22'(s1_q400) * 22'(cddn_pkg::DAYS_400));
  end

  always_ff @(posedge clk) begin
    s2_action <= s1_action;
    s2_valid0 <= (s1_year != 14'd0) && ({2'b00, s1_year} <= cddn_pkg::MAX_YEAR) &&
                 (s1_month >= 4'd1) && (s1_month <= 4'd12) && (s1_day != 5'd0) &&
                 (s1_day <= cddn_pkg::month_len(s1_month, s2_leap));
    s2_p      <= s1_year - 14'd1;
    // (year-1)/100 equals year/100 unless year is a whole century
    s2_p100   <= (s2_ry != 7'd0) ? s1_qy : s1_qy - 8'd1;
    s2_doy    <= cddn_pkg::month_start(s1_month, s2_leap) + 9'(s1_day) - 9'd1;
    s2_q400   <= s1_q400;
    s2_r      <= s2_r_full[17:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: 365 * (year-1) and the leap correction; century split
  // ---------------------------------------------------------------------------
  logic [1:0]  s3_q100_next;
  logic [17:0] s3_r2_full;

  always_comb begin
    // The last day of a 400-year cycle stays in the fourth century
    if (s2_r >= 18'(3 * cddn_pkg::DAYS_100)) begin
      s3_q100_next = 2'd3;
    end else if (s2_r >= 18'(2 * cddn_pkg::DAYS_100)) begin
      s3_q100_next = 2'd2;
    end else if (s2_r >= 18'(cddn_pkg::DAYS_100)) begin
      s3_q100_next = 2'd1;
    end else begin
      s3_q100_next = 2'd0;
    end
    s3_r2_full = s2_r - (18'(s3_q100_next) * 18'(cddn_pkg::DAYS_100));
  end

  always_ff @(posedge clk) begin
    s3_action <= s2_action;
    s3_valid0 <= s2_valid0;
    s3_a      <= 23'(s2_p) * 23'(cddn_pkg::DAYS_1);
    s3_corr   <= 13'(s2_p[13:2]) - 13'(s2_p100) + 13'(s2_p100[7:2]) + 13'(s2_doy);
    s3_q400   <= s2_q400;
    s3_q100   <= s3_q100_next;
    s3_r2     <= s3_r2_full[15:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 4: final day count; remainder / 1461 for the 4-year cycle
  // ---------------------------------------------------------------------------
  logic [22:0] s4_count_full;
  logic [31:0] q4_prod;

  assign s4_count_full = s3_a + 23'(s3_corr);
  assign q4_prod       = 32'(s3_r2) * 32'(cddn_pkg::D4_RECIP);

  always_ff @(posedge clk) begin
    s4_action <= s3_action;
    s4_valid0 <= s3_valid0;
    s4_count  <= s4_count_full[21:0];
    s4_q400   <= s3_q400;
    s4_q100   <= s3_q100;
    s4_q4     <= q4_prod[cddn_pkg::D4_SHIFT +: 5];
    s4_r2     <= s3_r2;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: single years within the 4-year cycle
  // ---------------------------------------------------------------------------
  logic [15:0] s5_r3_full;
  logic [10:0] s5_r3;
  logic [1:0]  s5_q1_next;
  logic [10:0] s5_r4_full;

  always_comb begin
    s5_r3_full = s4_r2 - (16'(s4_q4) * 16'(cddn_pkg::DAYS_4));
    s5_r3      = s5_r3_full[10:0];
    // Day 1460 of a 4-year cycle belongs to the leap year
    if (s5_r3 >= 11'(3 * cddn_pkg::DAYS_1)) begin
      s5_q1_next = 2'd3;
    end else if (s5_r3 >= 11'(2 * cddn_pkg::DAYS_1)) begin
      s5_q1_next = 2'd2;
    end else if (s5_r3 >= 11'(cddn_pkg::DAYS_1)) begin
      s5_q1_next = 2'd1;
    end else begin
      s5_q1_next = 2'd0;
    end
    s5_r4_full = s5_r3 - (11'(s5_q1_next) * 11'(cddn_pkg::DAYS_1));
  end

  always_ff @(posedge clk) begin
    s5_action <= s4_action;
    s5_valid0 <= s4_valid0;
    s5_count  <= s4_count;
    s5_q400   <= s4_q400;
    s5_q100   <= s4_q100;
    s5_q4     <= s4_q4;
    s5_q1     <= s5_q1_next;
    s5_r4     <= s5_r4_full[8:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 6: rebuild the year, search the month, build the result
  // ---------------------------------------------------------------------------
  logic [13:0] s6_year;
  logic        s6_leap;
  logic [3:0]  s6_month;
  logic [8:0]  s6_day_full;
  logic        s6_valid1;

  always_comb begin
    s6_year = (14'(s5_q400) * 14'd400) + (14'(s5_q100) * 14'd100) +
              14'({s5_q4, 2'b00}) + 14'(s5_q1) + 14'd1;
    // Year is leap when it closes a 4-year cycle, except a century that does
    // not close the 400-year cycle
    s6_leap = (s5_q1 == 2'd3) && ((s5_q4 != 5'd24) || (s5_q100 == 2'd3));
    s6_month = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (s5_r4 >= cddn_pkg::month_start(4'(k), s6_leap)) begin
        s6_month = 4'(k);
      end
    end
    s6_day_full = s5_r4 - cddn_pkg::month_start(s6_month, s6_leap) + 9'd1;
    s6_valid1   = ({2'b00, s6_year} <= cddn_pkg::MAX_YEAR);

    res_next = '0;
    if (s5_action == cddn_pkg::ACT_TO_COUNT) begin
      res_next.valid_res = s5_valid0;
      if (s5_valid0) begin
        res_next.count_out = s5_count;
      end
    end else begin
      res_next.valid_res = s6_valid1;
      if (s6_valid1) begin
        res_next.year_out  = s6_year;
        res_next.month_out = s6_month;
        res_next.day_out   = s6_day_full[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule
`default_nettype wire
